// ===== hw/rtl/wavp_pkg.sv =====
// Shared types, phase codes, chunk ids and status codes for the WAV PCM16 stream parser.
package wavp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] sample;
        logic [2:0]         status;
        logic [15:0]        channel_count;
        logic [31:0]        rate_hz;
    } t_out_item;

    typedef struct packed {
        logic [1:0] count;
        t_out_item  first;
        t_out_item  second;
    } t_res;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CHUNK,
        PH_FMT,
        PH_SKIP,
        PH_DATA,
        PH_IGNORE
    } t_phase;

    localparam logic [31:0] ID_RIFF = 32'h5249_4646;
    localparam logic [31:0] ID_WAVE = 32'h5741_5645;
    localparam logic [31:0] ID_FMT  = 32'h666D_7420;
    localparam logic [31:0] ID_DATA = 32'h6461_7461;

    localparam logic [31:0] DEFAULT_RATE     = 32'd44100;
    localparam logic [15:0] DEFAULT_CHANNELS = 16'd1;
    localparam logic [15:0] FMT_PCM          = 16'd1;
    localparam logic [15:0] PCM_BITS         = 16'd16;
    localparam logic [31:0] FMT_FIELD_BYTES  = 32'd16;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_END    = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
    localparam logic [2:0] ST_NOT_PCM16 = 3'd2;
    localparam logic [2:0] ST_NO_DATA   = 3'd3;
    localparam logic [2:0] ST_TRUNCATED = 3'd4;

endpackage

// ===== hw/rtl/wavp_parse.sv =====
// Byte-wise RIFF/WAVE chunk walker: parser state and the result items of each byte.
module wavp_parse
    import wavp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output t_res     o_res
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_bc, n_bc;
    logic [31:0] r_cr, n_cr;
    logic [31:0] r_id, n_id;
    logic        r_hok, n_hok;
    logic [15:0] r_fmt, n_fmt;
    logic [15:0] r_bits, n_bits;
    logic [15:0] r_ch, n_ch;
    logic [31:0] r_rate, n_rate;
    logic [7:0]  r_low, n_low;

    logic [7:0]  b;
    logic        eos;
    logic        has_sample;
    logic        has_end;
    logic        proc_end;
    logic [2:0]  end_status;
    t_out_item   smp_item;
    t_out_item   end_item;

    assign b   = i_item.data_byte;
    assign eos = i_item.end_of_stream;

    always_comb begin
        n_phase = r_phase;
        n_bc    = r_bc;
        n_cr    = r_cr;
        n_id    = r_id;
        n_hok   = r_hok;
        n_fmt   = r_fmt;
        n_bits  = r_bits;
        n_ch    = r_ch;
        n_rate  = r_rate;
        n_low   = r_low;
        case (r_phase)
            PH_HEADER: begin
                n_id = {r_id[23:0], b};
                if (r_bc == 4'd3 && n_id != ID_RIFF) begin
                    n_hok = 1'b0;
                end
                if (r_bc == 4'd11 && n_id != ID_WAVE) begin
                    n_hok = 1'b0;
                end
                n_bc = r_bc + 4'd1;
                if (r_bc == 4'd11) begin
                    n_bc    = '0;
                    n_phase = n_hok ? PH_CHUNK : PH_IGNORE;
                end
            end
            PH_CHUNK: begin
                case (r_bc)
                    4'd0, 4'd1, 4'd2, 4'd3: n_id = {r_id[23:0], b};
                    4'd4:    n_cr = {24'd0, b};
                    4'd5:    n_cr[15:8] = b;
                    4'd6:    n_cr[23:16] = b;
                    4'd7:    n_cr[31:24] = b;
                    default: n_cr = r_cr;
                endcase
                n_bc = r_bc + 4'd1;
                if (r_bc == 4'd7) begin
                    n_bc = '0;
                    if (n_id == ID_FMT && n_cr >= FMT_FIELD_BYTES) begin
                        n_phase = PH_FMT;
                    end else if (n_id == ID_DATA) begin
                        n_phase = (n_cr == '0) ? PH_IGNORE : PH_DATA;
                    end else if (n_cr != '0) begin
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_FMT: begin
                case (r_bc)
                    4'd0:    n_fmt = {8'd0, b};
                    4'd1:    n_fmt[15:8] = b;
                    4'd2:    n_ch = {8'd0, b};
                    4'd3:    n_ch[15:8] = b;
                    4'd4:    n_rate = {24'd0, b};
                    4'd5:    n_rate[15:8] = b;
                    4'd6:    n_rate[23:16] = b;
                    4'd7:    n_rate[31:24] = b;
                    4'd14:   n_bits = {8'd0, b};
                    4'd15:   n_bits[15:8] = b;
                    default: n_fmt = r_fmt;
                endcase
                n_bc = r_bc + 4'd1;
                if (r_bc == 4'd15) begin
                    n_bc = '0;
                    n_cr = r_cr - FMT_FIELD_BYTES;
                    if (n_fmt != FMT_PCM || n_bits != PCM_BITS) begin
                        n_phase = PH_IGNORE;
                    end else if (n_cr == '0) begin
                        n_phase = PH_CHUNK;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                n_cr = r_cr - 32'd1;
                if (r_cr == 32'd1) begin
                    n_bc    = '0;
                    n_phase = PH_CHUNK;
                end
            end
            PH_DATA: begin
                if (!r_bc[0]) begin
                    n_low = b;
                end
                n_bc = r_bc + 4'd1;
                n_cr = r_cr - 32'd1;
                if (r_cr == 32'd1) begin
                    n_phase = PH_IGNORE;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_comb begin
        has_sample = (r_phase == PH_DATA) && r_bc[0];
        proc_end   = (r_phase != PH_IGNORE) && (n_phase == PH_IGNORE);
        has_end    = proc_end || (eos && n_phase != PH_IGNORE);
        if (proc_end) begin
            case (r_phase)
                PH_HEADER: end_status = ST_NOT_RIFF;
                PH_FMT:    end_status = ST_NOT_PCM16;
                default:   end_status = ST_OK;
            endcase
        end else begin
            case (n_phase)
                PH_HEADER: end_status = ST_NOT_RIFF;
                PH_FMT:    end_status = ST_NOT_PCM16;
                PH_DATA:   end_status = ST_TRUNCATED;
                default:   end_status = ST_NO_DATA;
            endcase
        end

        smp_item               = '0;
        smp_item.kind          = KIND_SAMPLE;
        smp_item.sample        = $signed({b, r_low});

        end_item               = '0;
        end_item.kind          = KIND_END;
        end_item.status        = end_status;
        end_item.channel_count = (end_status == ST_OK) ? n_ch : '0;
        end_item.rate_hz       = (end_status == ST_OK) ? n_rate : '0;

        o_res = '0;
        if (has_sample) begin
            o_res.first  = smp_item;
            o_res.second = end_item;
            o_res.count  = has_end ? 2'd2 : 2'd1;
        end else begin
            o_res.first  = end_item;
            o_res.count  = has_end ? 2'd1 : 2'd0;
        end
        if (!i_accept) begin
            o_res.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && eos)) begin
            r_phase <= PH_HEADER;
            r_bc    <= '0;
            r_cr    <= '0;
            r_id    <= '0;
            r_hok   <= 1'b1;
            r_fmt   <= '0;
            r_bits  <= '0;
            r_ch    <= DEFAULT_CHANNELS;
            r_rate  <= DEFAULT_RATE;
            r_low   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_bc    <= n_bc;
            r_cr    <= n_cr;
            r_id    <= n_id;
            r_hok   <= n_hok;
            r_fmt   <= n_fmt;
            r_bits  <= n_bits;
            r_ch    <= n_ch;
            r_rate  <= n_rate;
            r_low   <= n_low;
        end
    end

    a_ignore_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_phase == PH_IGNORE) |-> (o_res.count == 2'd0))
        else $error("result produced while ignoring trailing bytes");

    a_data_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA || r_phase == PH_SKIP) |-> (r_cr != '0))
        else $error("data or skip phase with no bytes left");

endmodule

// ===== hw/rtl/wavp_outq.sv =====
// Result queue that takes up to two items per cycle and presents one per transfer.
module wavp_outq
    import wavp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_res      i_push,
    output logic      o_room,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_out_item r_mem [DEPTH];

    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] tail1;
    logic [PW-1:0] tail2;
    logic          pop;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        f_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign tail1   = f_inc(r_tail);
    assign tail2   = f_inc(tail1);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_head];
    assign pop     = o_valid && !i_stall;
    assign o_room  = (r_count <= CW'(DEPTH - 2));

    always_comb begin
        n_head  = pop ? f_inc(r_head) : r_head;
        n_count = r_count + CW'(i_push.count) - CW'(pop);
        case (i_push.count)
            2'd1:    n_tail = tail1;
            2'd2:    n_tail = tail2;
            default: n_tail = r_tail;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_tail] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[tail1] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_room)
        else $error("results pushed without room for two");

endmodule

// ===== hw/rtl/wav_pcm16_stream_parser.sv =====
// Top level of the WAV PCM16 stream parser: byte parser feeding a result queue.
// Takes one byte of a RIFF/WAVE file per cycle and returns signed 16-bit samples
// followed by one end item carrying status, channel count and sample rate. Every
// byte is handled in the cycle it is accepted, so while the result queue has room
// the sustained rate is one byte per cycle; a byte may yield two results (last
// sample plus end item), which enter a QUEUE_DEPTH-entry result queue together.
// Input stalls whenever that queue has fewer than two free entries, so a stalled
// output side stops input after QUEUE_DEPTH-1 pending results.
module wav_pcm16_stream_parser
    import wavp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic accept;
    logic room;
    t_res res;

    assign o_stall = !room;
    assign accept  = i_valid && room;

    wavp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_res    (res)
    );

    wavp_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule
